// File: sv/mapid_pkg.sv
// Shared types and constants for the multi-axis PID controller.
`timescale 1ns / 1ps

package mapid_pkg;

   localparam int AXIS_W      = 2;
   localparam int DATA_W      = 16;
   localparam int FRAC_W      = 12;
   localparam int GAIN_W      = 16;
   localparam int GAIN_REG_W  = 3 * GAIN_W;
   localparam int NUM_GAINS   = 4;
   localparam int ERR_W       = DATA_W + 1;
   localparam int DIFF_W      = ERR_W + 1;

   localparam logic signed [DATA_W-1:0] DRIVE_MAX = 16'sh7FFF;
   localparam logic signed [DATA_W-1:0] DRIVE_MIN = 16'sh8000;

   typedef enum logic [AXIS_W-1:0] {
      CSR_GAINS_AXIS0 = 2'd0,
      CSR_GAINS_AXIS1 = 2'd1,
      CSR_GAINS_AXIS2 = 2'd2,
      CSR_GAINS_AXIS3 = 2'd3
   } csr_index_type;

   // Packed so that kp sits in bits 15:0, ki*dt in 31:16 and kd/dt in 47:32.
   typedef struct packed {
      logic signed [GAIN_W-1:0] kd;
      logic signed [GAIN_W-1:0] ki;
      logic signed [GAIN_W-1:0] kp;
   } gains_type;

   // Reset gains: kp = 0.1, 0.1, 1/6.28 and 0; integral and derivative gains zero.
   localparam logic [GAIN_REG_W-1:0] GAINS_RESET [NUM_GAINS] = '{
      48'd410, 48'd410, 48'd652, 48'd0
   };

endpackage

// File: sv/mapid_req_if.sv
// Request channel carrying one axis update item.
`timescale 1ns / 1ps

interface mapid_req_if;
   import mapid_pkg::*;

   logic                     valid;
   logic                     ready;
   logic [AXIS_W-1:0]        axis;
   logic signed [DATA_W-1:0] measured_value;
   logic signed [DATA_W-1:0] setpoint;

   modport source (output valid, output axis, output measured_value, output setpoint,
                   input ready);
   modport sink   (input valid, input axis, input measured_value, input setpoint,
                   output ready);
endinterface

// File: sv/mapid_rsp_if.sv
// Response channel carrying one controller output item.
`timescale 1ns / 1ps

interface mapid_rsp_if;
   import mapid_pkg::*;

   logic                     valid;
   logic                     ready;
   logic [AXIS_W-1:0]        axis_out;
   logic signed [DATA_W-1:0] drive;
   logic                     saturated;

   modport source (output valid, output axis_out, output drive, output saturated,
                   input ready);
   modport sink   (input valid, input axis_out, input drive, input saturated,
                   output ready);
endinterface

// File: sv/mapid_csr.sv
// Gain register file, one packed gain word per axis.
`timescale 1ns / 1ps

module mapid_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  mapid_pkg::csr_index_type          csr_index,
   input  logic [mapid_pkg::GAIN_REG_W-1:0]  csr_wdata,
   output mapid_pkg::gains_type              gains [mapid_pkg::NUM_GAINS]
);
   import mapid_pkg::*;

   logic [GAIN_REG_W-1:0] gains_ff [NUM_GAINS];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_GAINS; i++) begin
            gains_ff[i] <= GAINS_RESET[i];
         end
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_GAINS_AXIS0: gains_ff[0] <= csr_wdata;
            CSR_GAINS_AXIS1: gains_ff[1] <= csr_wdata;
            CSR_GAINS_AXIS2: gains_ff[2] <= csr_wdata;
            CSR_GAINS_AXIS3: gains_ff[3] <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      for (int i = 0; i < NUM_GAINS; i++) begin
         gains[i] = gains_type'(gains_ff[i]);
      end
   end

endmodule

// File: sv/mapid_err.sv
// Input register and error stage with the per-axis integral and previous-error state.
`timescale 1ns / 1ps

module mapid_err #(
   parameter int AXES           = 4,
   parameter int INTEGRAL_WIDTH = 32
) (
   input  logic                                    clock,
   input  logic                                    reset,
   mapid_req_if.sink                               req_ch,
   input  mapid_pkg::gains_type                    gains [mapid_pkg::NUM_GAINS],
   output logic                                    err_valid,
   input  logic                                    err_ready,
   output logic [mapid_pkg::AXIS_W-1:0]            err_axis,
   output logic signed [mapid_pkg::ERR_W-1:0]      err_e,
   output logic signed [INTEGRAL_WIDTH-1:0]        err_isum,
   output logic signed [mapid_pkg::DIFF_W-1:0]     err_diff,
   output mapid_pkg::gains_type                    err_gains
);
   import mapid_pkg::*;

   localparam int AW = (AXES > 1) ? $clog2(AXES) : 1;
   localparam int IW = INTEGRAL_WIDTH;

   // Input register.
   logic                     in_valid_ff;
   logic [AXIS_W-1:0]        in_axis_ff;
   logic signed [DATA_W-1:0] in_meas_ff;
   logic signed [DATA_W-1:0] in_set_ff;

   // Error stage register.
   logic                     e_valid_ff;
   logic [AXIS_W-1:0]        e_axis_ff;
   logic signed [ERR_W-1:0]  e_err_ff;
   logic signed [IW-1:0]     e_isum_ff;
   logic signed [DIFF_W-1:0] e_diff_ff;
   gains_type                e_gains_ff;

   // Per-axis state.
   logic signed [IW-1:0]     integral_ff [AXES];
   logic signed [ERR_W-1:0]  prev_err_ff [AXES];

   logic                     e_rdy;
   logic                     in_rdy;
   logic                     advance;
   logic                     in_range;
   logic [AW-1:0]            idx;
   logic signed [ERR_W-1:0]  err_in;
   logic signed [IW:0]       sum_wide;
   logic signed [IW-1:0]     isum_in;
   logic signed [DIFF_W-1:0] diff_in;
   gains_type                gains_in;

   assign e_rdy        = !e_valid_ff || err_ready;
   assign in_rdy       = !in_valid_ff || e_rdy;
   assign req_ch.ready = in_rdy;
   assign advance      = in_valid_ff && e_rdy;

   always_comb begin
      in_range = 32'(in_axis_ff) < AXES;
      // An axis with no state reads entry zero, so the state read never leaves the array.
      idx      = in_range ? AW'(in_axis_ff) : '0;
      err_in   = ERR_W'(in_set_ff) - ERR_W'(in_meas_ff);
      sum_wide = (IW + 1)'(integral_ff[idx]) + (IW + 1)'(err_in);
      // The integral clips at its signed range when the two top bits disagree.
      if (sum_wide[IW] != sum_wide[IW-1]) begin
         isum_in = sum_wide[IW] ? {1'b1, {(IW-1){1'b0}}} : {1'b0, {(IW-1){1'b1}}};
      end else begin
         isum_in = sum_wide[IW-1:0];
      end
      diff_in  = DIFF_W'(err_in) - DIFF_W'(prev_err_ff[idx]);
      // An axis with no state gives zero gains, so its drive comes out zero.
      gains_in = in_range ? gains[in_axis_ff] : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (in_rdy) begin
         in_valid_ff <= req_ch.valid;
      end
      if (in_rdy && req_ch.valid) begin
         in_axis_ff <= req_ch.axis;
         in_meas_ff <= req_ch.measured_value;
         in_set_ff  <= req_ch.setpoint;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         e_valid_ff <= 1'b0;
      end else if (e_rdy) begin
         e_valid_ff <= in_valid_ff;
      end
      if (advance) begin
         e_axis_ff  <= in_axis_ff;
         e_err_ff   <= err_in;
         e_isum_ff  <= isum_in;
         e_diff_ff  <= diff_in;
         e_gains_ff <= gains_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < AXES; i++) begin
            integral_ff[i] <= '0;
            prev_err_ff[i] <= '0;
         end
      end else if (advance && in_range) begin
         integral_ff[idx] <= isum_in;
         prev_err_ff[idx] <= err_in;
      end
   end

   assign err_valid    = e_valid_ff;
   assign err_axis     = e_axis_ff;
   assign err_e        = e_err_ff;
   assign err_isum     = e_isum_ff;
   assign err_diff     = e_diff_ff;
   assign err_gains    = e_gains_ff;

endmodule

// File: sv/mapid_mac.sv
// Product stage and the rounding and saturating output register.
`timescale 1ns / 1ps

module mapid_mac #(
   parameter int INTEGRAL_WIDTH = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                err_valid,
   output logic                                err_ready,
   input  logic [mapid_pkg::AXIS_W-1:0]        err_axis,
   input  logic signed [mapid_pkg::ERR_W-1:0]  err_e,
   input  logic signed [INTEGRAL_WIDTH-1:0]    err_isum,
   input  logic signed [mapid_pkg::DIFF_W-1:0] err_diff,
   input  mapid_pkg::gains_type                err_gains,
   mapid_rsp_if.source                         rsp_ch
);
   import mapid_pkg::*;

   localparam int IW    = INTEGRAL_WIDTH;
   localparam int PKP_W = GAIN_W + ERR_W;
   localparam int PKI_W = GAIN_W + IW;
   localparam int PKD_W = GAIN_W + DIFF_W;
   localparam int ACC_W = IW + 18;
   localparam int TOP   = FRAC_W + DATA_W - 1;

   logic                     p_valid_ff;
   logic [AXIS_W-1:0]        p_axis_ff;
   logic signed [PKP_W-1:0]  p_kp_ff;
   logic signed [PKI_W-1:0]  p_ki_ff;
   logic signed [PKD_W-1:0]  p_kd_ff;

   logic                     o_valid_ff;
   logic [AXIS_W-1:0]        o_axis_ff;
   logic signed [DATA_W-1:0] o_drive_ff;
   logic                     o_sat_ff;

   logic                     o_rdy;
   logic                     p_rdy;
   logic signed [PKP_W-1:0]  p_kp_in;
   logic signed [PKI_W-1:0]  p_ki_in;
   logic signed [PKD_W-1:0]  p_kd_in;
   logic signed [ACC_W-1:0]  acc;
   logic [ACC_W-TOP-1:0]     acc_hi;
   logic signed [DATA_W-1:0] drive_in;
   logic                     sat_in;

   assign o_rdy     = !o_valid_ff || rsp_ch.ready;
   assign p_rdy     = !p_valid_ff || o_rdy;
   assign err_ready = p_rdy;

   always_comb begin
      p_kp_in = PKP_W'(err_gains.kp) * PKP_W'(err_e);
      p_ki_in = PKI_W'(err_gains.ki) * PKI_W'(err_isum);
      p_kd_in = PKD_W'(err_gains.kd) * PKD_W'(err_diff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p_valid_ff <= 1'b0;
      end else if (p_rdy) begin
         p_valid_ff <= err_valid;
      end
      if (p_rdy && err_valid) begin
         p_axis_ff <= err_axis;
         p_kp_ff   <= p_kp_in;
         p_ki_ff   <= p_ki_in;
         p_kd_ff   <= p_kd_in;
      end
   end

   // The sum is at Q38.12 scale; adding half an output step and dropping the
   // fraction rounds to nearest with ties going up.
   always_comb begin
      acc    = ACC_W'(p_kp_ff) + ACC_W'(p_ki_ff) + ACC_W'(p_kd_ff)
             + ACC_W'(1 << (FRAC_W - 1));
      acc_hi = acc[ACC_W-1:TOP];
      sat_in = !((&acc_hi) || !(|acc_hi));
      if (sat_in) begin
         drive_in = acc[ACC_W-1] ? DRIVE_MIN : DRIVE_MAX;
      end else begin
         drive_in = acc[TOP:FRAC_W];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         o_valid_ff <= 1'b0;
      end else if (o_rdy) begin
         o_valid_ff <= p_valid_ff;
      end
      if (o_rdy && p_valid_ff) begin
         o_axis_ff  <= p_axis_ff;
         o_drive_ff <= drive_in;
         o_sat_ff   <= sat_in;
      end
   end

   assign rsp_ch.valid     = o_valid_ff;
   assign rsp_ch.axis_out  = o_axis_ff;
   assign rsp_ch.drive     = o_drive_ff;
   assign rsp_ch.saturated = o_sat_ff;

endmodule

// File: sv/multi_axis_pid_controller.sv
// Top level of the time-shared multi-axis PID controller.
`timescale 1ns / 1ps

// Each item updates one axis: error = setpoint - measured_value, the axis integral
// accumulates the error with saturation, and the drive is kp*e + ki*I + kd*(e - prev)
// rounded to a Q16.0 integer and clipped to 16 bits, with a flag when clipped. Gains
// are packed per axis in the csr registers (kp 15:0, ki*dt 31:16, kd/dt 47:32) and
// should only be written while no item is in flight. The block takes one item every
// cycle while the response side accepts; the accepting edge loads the input register,
// and the error stage, product stage and output register follow in that order before
// a result is offered. Up to four items are held while the response side stalls. The
// per-axis integral and previous error are read, updated and written back at the
// edge that loads the error stage, so items for the same axis may follow each other
// back to back. Items for an axis at or beyond AXES return a zero drive and leave
// all state alone.
module multi_axis_pid_controller #(
   parameter int AXES           = 4,
   parameter int INTEGRAL_WIDTH = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   mapid_req_if.sink                         req_ch,
   mapid_rsp_if.source                       rsp_ch,
   input  logic                              csr_we,
   input  mapid_pkg::csr_index_type          csr_index,
   input  logic [mapid_pkg::GAIN_REG_W-1:0]  csr_wdata
);
   import mapid_pkg::*;

   gains_type                gains [NUM_GAINS];
   logic                     err_valid;
   logic                     err_ready;
   logic [AXIS_W-1:0]        err_axis;
   logic signed [ERR_W-1:0]  err_e;
   logic signed [INTEGRAL_WIDTH-1:0] err_isum;
   logic signed [DIFF_W-1:0] err_diff;
   gains_type                err_gains;

   mapid_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .gains     (gains)
   );

   mapid_err #(
      .AXES           (AXES),
      .INTEGRAL_WIDTH (INTEGRAL_WIDTH)
   ) u_err (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .gains     (gains),
      .err_valid (err_valid),
      .err_ready (err_ready),
      .err_axis  (err_axis),
      .err_e     (err_e),
      .err_isum  (err_isum),
      .err_diff  (err_diff),
      .err_gains (err_gains)
   );

   mapid_mac #(
      .INTEGRAL_WIDTH (INTEGRAL_WIDTH)
   ) u_mac (
      .clock     (clock),
      .reset     (reset),
      .err_valid (err_valid),
      .err_ready (err_ready),
      .err_axis  (err_axis),
      .err_e     (err_e),
      .err_isum  (err_isum),
      .err_diff  (err_diff),
      .err_gains (err_gains),
      .rsp_ch    (rsp_ch)
   );

endmodule

// File: dv/multi_axis_pid_controller_tb.sv
// Self-checking testbench for the multi-axis PID controller with an item-level predictor.
`timescale 1ns / 1ps

module multi_axis_pid_controller_tb;
   import mapid_pkg::*;

   localparam int AXIS_COUNT  = 4;
   localparam int INTEG_W     = 32;
   localparam int LATENCY     = 4;
   localparam int STALL_LIMIT = 2000;
   localparam int HOLD_CYCLES = 300;
   localparam int HOLD_AFTER  = 150;
   localparam longint INTEG_MAX = (64'sd1 <<< (INTEG_W - 1)) - 1;
   localparam longint INTEG_MIN = -INTEG_MAX - 1;

   typedef struct {
      logic [AXIS_W-1:0]        axis;
      logic signed [DATA_W-1:0] measured;
      logic signed [DATA_W-1:0] target;
   } axis_update_type;

   typedef struct {
      logic [AXIS_W-1:0]        axis;
      logic signed [DATA_W-1:0] drive;
      logic                     saturated;
   } drive_result_type;

   logic clock = 1'b0;
   logic reset;
   logic csr_we;
   csr_index_type csr_index;
   logic [GAIN_REG_W-1:0] csr_wdata;

   mapid_req_if req_if ();
   mapid_rsp_if rsp_if ();

   multi_axis_pid_controller #(
      .AXES           (AXIS_COUNT),
      .INTEGRAL_WIDTH (INTEG_W)
   ) DUT (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_if),
      .rsp_ch    (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #2 clock = ~clock;

   // Predictor state: gains as last written, per-axis integral and previous error.
   gains_type                pid_gains [AXIS_COUNT];
   logic signed [INTEG_W-1:0] integ_sum [AXIS_COUNT];
   logic signed [ERR_W-1:0]   prev_err  [AXIS_COUNT];

   axis_update_type  pending_updates[$];
   drive_result_type expected_drives[$];
   axis_update_type  offered;
   bit               calm;
   int               mismatches;
   int               results_seen;
   int               hold_left;
   bit               hold_done;
   int               stall_cycles;

   function automatic drive_result_type predict_drive(axis_update_type u);
      gains_type        g;
      longint           err;
      longint           isum;
      longint           delta;
      longint           acc;
      longint           y;
      drive_result_type r;
      g     = pid_gains[u.axis];
      err   = longint'(u.target) - longint'(u.measured);
      isum  = longint'(integ_sum[u.axis]) + err;
      if (isum > INTEG_MAX) begin
         isum = INTEG_MAX;
      end else if (isum < INTEG_MIN) begin
         isum = INTEG_MIN;
      end
      delta = err - longint'(prev_err[u.axis]);
      acc   = longint'(g.kp) * err + longint'(g.ki) * isum + longint'(g.kd) * delta;
      // Round to nearest with ties upward: add half an LSB, then floor.
      y     = (acc + (64'sd1 <<< (FRAC_W - 1))) >>> FRAC_W;
      r.axis      = u.axis;
      r.saturated = 1'b0;
      if (y > longint'(DRIVE_MAX)) begin
         y = DRIVE_MAX;
         r.saturated = 1'b1;
      end else if (y < longint'(DRIVE_MIN)) begin
         y = DRIVE_MIN;
         r.saturated = 1'b1;
      end
      r.drive = DATA_W'(y);
      integ_sum[u.axis] = INTEG_W'(isum);
      prev_err[u.axis]  = ERR_W'(err);
      return r;
   endfunction

   function automatic logic signed [DATA_W-1:0] clip16(int v);
      if (v > 32767) begin
         return DRIVE_MAX;
      end else if (v < -32768) begin
         return DRIVE_MIN;
      end
      return DATA_W'(v);
   endfunction

   function automatic logic signed [DATA_W-1:0] edge_value();
      case ($urandom_range(0, 3))
         0: return DRIVE_MIN;
         1: return DRIVE_MAX;
         2: return '0;
         default: return DATA_W'($urandom);
      endcase
   endfunction

   function automatic axis_update_type random_update();
      axis_update_type u;
      int              mode;
      mode       = $urandom_range(0, 99);
      u.axis     = AXIS_W'($urandom_range(0, AXIS_COUNT - 1));
      u.measured = DATA_W'($urandom);
      if (mode < 40) begin
         u.target = DATA_W'($urandom);
      end else if (mode < 80) begin
         // Tracking: target close to the measurement, so outputs mostly stay in range.
         u.target = clip16(int'(u.measured) + int'($urandom_range(0, 512)) - 256);
      end else begin
         u.measured = edge_value();
         u.target   = edge_value();
      end
      return u;
   endfunction

   function automatic gains_type random_gains(bit narrow);
      gains_type g;
      if (narrow) begin
         g.kp = GAIN_W'(int'($urandom_range(0, 4096)) - 2048);
         g.ki = GAIN_W'(int'($urandom_range(0, 256)) - 128);
         g.kd = GAIN_W'(int'($urandom_range(0, 4096)) - 2048);
      end else begin
         g = gains_type'(GAIN_REG_W'({$urandom, $urandom}));
      end
      return g;
   endfunction

   task automatic queue_update(int axis, int measured, int target);
      axis_update_type u;
      u.axis     = AXIS_W'(axis);
      u.measured = DATA_W'(measured);
      u.target   = DATA_W'(target);
      pending_updates.push_back(u);
   endtask

   task automatic write_gains(csr_index_type idx, gains_type g);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= g;
      pid_gains[idx] = g;
   endtask

   task automatic load_all_gains(gains_type g0, gains_type g1, gains_type g2, gains_type g3);
      write_gains(CSR_GAINS_AXIS0, g0);
      write_gains(CSR_GAINS_AXIS1, g1);
      write_gains(CSR_GAINS_AXIS2, g2);
      write_gains(CSR_GAINS_AXIS3, g3);
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // Wait until every queued item has been sent and every result has come back.
   task automatic drain();
      do begin
         @(posedge clock);
      end while (pending_updates.size() != 0 || req_if.valid || expected_drives.size() != 0);
      repeat (2 * LATENCY) @(posedge clock);
   endtask

   // Sender: offers items from the pending queue and predicts each accepted one.
   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
      end else begin
         if (req_if.valid && req_if.ready) begin
            expected_drives.push_back(predict_drive(offered));
         end
         if (!req_if.valid || req_if.ready) begin
            if (pending_updates.size() != 0 && (calm || $urandom_range(0, 99) >= 15)) begin
               offered = pending_updates.pop_front();
               req_if.valid          <= 1'b1;
               req_if.axis           <= offered.axis;
               req_if.measured_value <= offered.measured;
               req_if.setpoint       <= offered.target;
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   // Receiver: checks each accepted result against the oldest prediction.
   always @(posedge clock) begin
      drive_result_type want;
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            results_seen++;
            if (expected_drives.size() == 0) begin
               mismatches++;
               $display("%0t: unexpected item: expected none, got axis %0d drive %0d sat %0b",
                        $time, rsp_if.axis_out, rsp_if.drive, rsp_if.saturated);
            end else begin
               want = expected_drives.pop_front();
               if (rsp_if.axis_out !== want.axis || rsp_if.drive !== want.drive ||
                   rsp_if.saturated !== want.saturated) begin
                  mismatches++;
                  $display("%0t: mismatch: expected axis %0d drive %0d sat %0b,",
                           $time, want.axis, want.drive, want.saturated,
                           " got axis %0d drive %0d sat %0b",
                           rsp_if.axis_out, rsp_if.drive, rsp_if.saturated);
               end
            end
         end
         // One long hold-off so that the pipeline backs up into the sender.
         if (hold_left > 0) begin
            hold_left--;
            rsp_if.ready <= 1'b0;
         end else if (!hold_done && results_seen >= HOLD_AFTER) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= calm || $urandom_range(0, 99) >= 15;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      gains_type g_tie;
      reset        = 1'b1;
      csr_we       = 1'b0;
      csr_index    = CSR_GAINS_AXIS0;
      csr_wdata    = '0;
      req_if.valid = 1'b0;
      req_if.axis  = '0;
      req_if.measured_value = '0;
      req_if.setpoint       = '0;
      rsp_if.ready = 1'b0;
      calm         = 1'b0;
      mismatches   = 0;
      results_seen = 0;
      hold_left    = 0;
      hold_done    = 1'b0;
      for (int i = 0; i < AXIS_COUNT; i++) begin
         pid_gains[i] = gains_type'(GAINS_RESET[i]);
         integ_sum[i] = '0;
         prev_err[i]  = '0;
      end
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Reset gains: the first update of each axis sees a zero previous error, then the
      // error swings across its whole range so the error difference is at its extreme.
      for (int a = 0; a < AXIS_COUNT; a++) begin
         queue_update(a, -32768, 32767);
         queue_update(a, 32767, -32768);
      end
      drain();

      // Rounding ties with kp = 0.5, and the gain extremes driving into saturation.
      g_tie = '{kd: '0, ki: '0, kp: 16'sd2048};
      load_all_gains(g_tie, gains_type'(48'h7FFF_7FFF_7FFF), gains_type'(48'h8000_8000_8000),
                     gains_type'(48'hFFFF_FFFF_FFFF));
      queue_update(0, 0, 1);
      queue_update(0, 0, -1);
      queue_update(0, 0, 3);
      queue_update(0, 0, -3);
      queue_update(1, -32768, 32767);
      queue_update(1, 32767, -32768);
      queue_update(1, 0, 0);
      queue_update(2, -32768, 32767);
      queue_update(2, 32767, -32768);
      queue_update(3, 0, 1);
      queue_update(3, 32767, -32768);
      queue_update(3, -32768, 32767);
      drain();

      for (int ph = 0; ph < 5; ph++) begin
         case (ph)
            0: load_all_gains(random_gains(1), random_gains(1), random_gains(1), random_gains(1));
            1: load_all_gains(random_gains(0), random_gains(0), random_gains(0), random_gains(0));
            2: load_all_gains(gains_type'(48'h7FFF_7FFF_7FFF), gains_type'(48'h0),
                              gains_type'(48'h8000_8000_8000), random_gains(1));
            3: load_all_gains(random_gains(1), random_gains(0), random_gains(1), random_gains(1));
            default: load_all_gains(gains_type'(GAINS_RESET[0]), gains_type'(GAINS_RESET[1]),
                                    gains_type'(GAINS_RESET[2]), gains_type'(GAINS_RESET[3]));
         endcase
         calm = (ph == 3);
         repeat (ph == 0 ? 250 : 190) pending_updates.push_back(random_update());
         drain();
      end
      calm = 1'b0;

      if (mismatches == 0 && expected_drives.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
